@@ hw/rtl/pirl_pkg.sv @@
// ----------------------------------------------------------------------------
// pirl_pkg
// Shared types, codes and field widths of the positional insert/remove list.
// ----------------------------------------------------------------------------
package pirl_pkg;

    // Default configuration
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the port fields
    localparam int KIND_W   = 2;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int ELEM_W   = 32;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;

    // Operation requested by an input item
    typedef enum logic [KIND_W-1:0] {
        K_INSERT     = 2'd0,
        K_REMOVE_POS = 2'd1,
        K_REMOVE_VAL = 2'd2,
        K_READ_ALL   = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_POS   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE         = 3'd0,
        OP_LOAD         = 3'd1,
        OP_COMPARE      = 3'd2,
        OP_INSERT       = 3'd3,
        OP_REMOVE_POS   = 3'd4,
        OP_REMOVE_FOUND = 3'd5,
        OP_READ_EMPTY   = 3'd6,
        OP_READ_ONE     = 3'd7
    } t_op;

    // Controller to datapath command
    typedef struct packed {
        t_op  op;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_kind kind;
        logic  empty;
        logic  read_last;
    } t_dp_stat;

endpackage

@@ hw/rtl/positional_insert_remove_list_unit.sv @@
// ----------------------------------------------------------------------------
// positional_insert_remove_list_unit
// Ordered list with insert and remove at a position, remove by masked value
// and read-all, behind valid/stall channels.
// ----------------------------------------------------------------------------
// One item is in work at a time. Insert and remove at a position latch the
// item, then shift all cells at once; remove by value latches the item, then
// does a masked compare of all cells into a registered match vector, then a
// first-match encode and shift; read all latches the item, then gives one
// result per cycle while the result register is not stalled (a single empty
// result on an empty list), limited by the single result register, while the
// datapath rotates the cells so that each entry is read from cell 0.
// A stalled result register holds the controller until it drains. A full
// insert is dropped and flagged. The match mask port is always ready and
// should be written only while the list is idle.
module positional_insert_remove_list_unit #(
    parameter int CAPACITY   = pirl_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pirl_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [pirl_pkg::KIND_W-1:0]    i_kind,
    input  logic [pirl_pkg::POS_W-1:0]     i_position,
    input  logic [pirl_pkg::VALUE_W-1:0]   i_value,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pirl_pkg::STATUS_W-1:0]  o_status,
    output logic [pirl_pkg::ELEM_W-1:0]    o_element,
    output logic [pirl_pkg::INDEX_W-1:0]   o_element_index,
    output logic [pirl_pkg::COUNT_W-1:0]   o_count,
    output logic                           o_last,
    // match mask write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pirl_pkg::VALUE_W-1:0]   i_cfg_data
);

    pirl_pkg::t_dp_cmd  cmd;
    pirl_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    pirl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pirl_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (i_kind),
        .i_position      (i_position),
        .i_value         (i_value),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_status        (o_status),
        .o_element       (o_element),
        .o_element_index (o_element_index),
        .o_count         (o_count),
        .o_last          (o_last)
    );

endmodule

@@ hw/rtl/pirl_dp.sv @@
// ----------------------------------------------------------------------------
// pirl_dp
// Datapath: row of entry cells with parallel shift, masked match vector,
// first-match encoder and the result register.
// ----------------------------------------------------------------------------
module pirl_dp #(
    parameter int CAPACITY   = pirl_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pirl_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pirl_pkg::t_dp_cmd              i_cmd,
    output pirl_pkg::t_dp_stat             o_stat,
    input  logic [pirl_pkg::KIND_W-1:0]    i_kind,
    input  logic [pirl_pkg::POS_W-1:0]     i_position,
    input  logic [pirl_pkg::VALUE_W-1:0]   i_value,
    input  logic                           i_cfg_we,
    input  logic [pirl_pkg::VALUE_W-1:0]   i_cfg_data,
    output logic [pirl_pkg::STATUS_W-1:0]  o_status,
    output logic [pirl_pkg::ELEM_W-1:0]    o_element,
    output logic [pirl_pkg::INDEX_W-1:0]   o_element_index,
    output logic [pirl_pkg::COUNT_W-1:0]   o_count,
    output logic                           o_last
);

    localparam int CW = $clog2(CAPACITY + 1);

    // State
    logic [DATA_WIDTH-1:0]         r_cell [CAPACITY];
    logic [DATA_WIDTH-1:0]         n_cell [CAPACITY];
    logic [CW-1:0]                 r_count, n_count;
    pirl_pkg::t_kind               r_kind;
    logic [pirl_pkg::POS_W-1:0]    r_pos;
    logic [DATA_WIDTH-1:0]         r_val;
    logic [DATA_WIDTH-1:0]         r_mask;
    logic [CAPACITY-1:0]           r_hit, n_hit;
    logic [CW-1:0]                 r_rd_idx, n_rd_idx;

    // Result register
    pirl_pkg::t_status             r_status, n_status;
    logic [pirl_pkg::ELEM_W-1:0]   r_element, n_element;
    logic [pirl_pkg::INDEX_W-1:0]  r_index, n_index;
    logic [pirl_pkg::COUNT_W-1:0]  r_count_out, n_count_out;
    logic                          r_last, n_last;

    // Width adaptation
    logic [DATA_WIDTH+pirl_pkg::VALUE_W-1:0] val_ext, mask_ext;
    logic [DATA_WIDTH+pirl_pkg::ELEM_W-1:0]  elem_ext;
    logic [CW+pirl_pkg::POS_W-1:0]           pos_ext, cnt_ext;
    logic [CW+pirl_pkg::INDEX_W-1:0]         rd_ext, found_ext;
    logic [CW+pirl_pkg::COUNT_W-1:0]         cnt_out_ext;

    logic          full, rem_bad, found;
    logic [CW-1:0] ins_p, rem_p, found_p, del_p, cnt_m1, rd_next;
    logic          do_delete;

    assign val_ext  = {{DATA_WIDTH{1'b0}}, i_value};
    assign mask_ext = {{DATA_WIDTH{1'b0}}, i_cfg_data};
    assign elem_ext = {{pirl_pkg::ELEM_W{1'b0}}, r_cell[0]};
    assign pos_ext  = {{CW{1'b0}}, r_pos};
    assign cnt_ext  = {{pirl_pkg::POS_W{1'b0}}, r_count};

    // Position decode
    assign full    = (r_count == CW'(CAPACITY));
    assign ins_p   = (pos_ext > cnt_ext) ? r_count : pos_ext[CW-1:0];
    assign rem_bad = (pos_ext >= cnt_ext);
    assign rem_p   = pos_ext[CW-1:0];
    assign cnt_m1  = r_count - CW'(1);
    assign rd_next = r_rd_idx + CW'(1);

    // Masked compare of every live cell against the requested value
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_hit[i] = (CW'(i) < r_count) && (((r_cell[i] ^ r_val) & r_mask) == '0);
        end
    end

    // Lowest set bit of the registered match vector
    always_comb begin
        found_p = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                found_p = CW'(i);
            end
        end
    end
    assign found = |r_hit;

    assign rd_ext      = {{pirl_pkg::INDEX_W{1'b0}}, r_rd_idx};
    assign found_ext   = {{pirl_pkg::INDEX_W{1'b0}}, found_p};
    assign del_p       = (i_cmd.op == pirl_pkg::OP_REMOVE_FOUND) ? found_p : rem_p;
    assign do_delete   = ((i_cmd.op == pirl_pkg::OP_REMOVE_POS) && !rem_bad) ||
                         ((i_cmd.op == pirl_pkg::OP_REMOVE_FOUND) && found);

    // Next cell contents and count
    always_comb begin
        n_cell  = r_cell;
        n_count = r_count;
        case (i_cmd.op)
            pirl_pkg::OP_INSERT: begin
                if (!full) begin
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (CW'(i) > ins_p) begin
                            n_cell[i] = r_cell[i-1];
                        end
                    end
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (CW'(i) == ins_p) begin
                            n_cell[i] = r_val;
                        end
                    end
                    n_count = r_count + CW'(1);
                end
            end
            pirl_pkg::OP_REMOVE_POS, pirl_pkg::OP_REMOVE_FOUND: begin
                if (do_delete) begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (CW'(i) >= del_p) begin
                            n_cell[i] = r_cell[i+1];
                        end
                    end
                    n_count = cnt_m1;
                end
            end
            pirl_pkg::OP_READ_ONE: begin
                // rotate the live entries down by one, head wraps to the tail
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    n_cell[i] = r_cell[i+1];
                end
                for (int i = 0; i < CAPACITY; i++) begin
                    if (CW'(i) == cnt_m1) begin
                        n_cell[i] = r_cell[0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign cnt_out_ext = {{pirl_pkg::COUNT_W{1'b0}}, n_count};

    // Read counter
    always_comb begin
        n_rd_idx = r_rd_idx;
        case (i_cmd.op)
            pirl_pkg::OP_LOAD:     n_rd_idx = '0;
            pirl_pkg::OP_READ_ONE: n_rd_idx = rd_next;
            default:               n_rd_idx = r_rd_idx;
        endcase
    end

    // Result fields
    always_comb begin
        n_status    = pirl_pkg::ST_OK;
        n_element   = '0;
        n_index     = '0;
        n_count_out = cnt_out_ext[pirl_pkg::COUNT_W-1:0];
        n_last      = 1'b1;
        case (i_cmd.op)
            pirl_pkg::OP_INSERT: begin
                n_status = full ? pirl_pkg::ST_FULL : pirl_pkg::ST_OK;
            end
            pirl_pkg::OP_REMOVE_POS: begin
                n_status = rem_bad ? pirl_pkg::ST_BAD_POS : pirl_pkg::ST_OK;
            end
            pirl_pkg::OP_REMOVE_FOUND: begin
                n_status = found ? pirl_pkg::ST_OK : pirl_pkg::ST_NOT_FOUND;
                n_index  = found ? found_ext[pirl_pkg::INDEX_W-1:0] : '0;
            end
            pirl_pkg::OP_READ_EMPTY: begin
                n_status = pirl_pkg::ST_EMPTY;
            end
            pirl_pkg::OP_READ_ONE: begin
                n_element = elem_ext[pirl_pkg::ELEM_W-1:0];
                n_index   = rd_ext[pirl_pkg::INDEX_W-1:0];
                n_last    = (rd_next == r_count);
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_mask   <= '1;
            r_rd_idx <= '0;
        end else begin
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            if (i_cfg_we) begin
                r_mask <= mask_ext[DATA_WIDTH-1:0];
            end
        end
    end

    // Payload: cells, latched item, match vector, result fields
    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (i_cmd.op == pirl_pkg::OP_LOAD) begin
            r_kind <= pirl_pkg::t_kind'(i_kind);
            r_pos  <= i_position;
            r_val  <= val_ext[DATA_WIDTH-1:0];
        end
        if (i_cmd.op == pirl_pkg::OP_COMPARE) begin
            r_hit <= n_hit;
        end
        if (i_cmd.emit) begin
            r_status    <= n_status;
            r_element   <= n_element;
            r_index     <= n_index;
            r_count_out <= n_count_out;
            r_last      <= n_last;
        end
    end

    assign o_stat.kind      = r_kind;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.read_last = (rd_next == r_count);

    assign o_status        = r_status;
    assign o_element       = r_element;
    assign o_element_index = r_index;
    assign o_count         = r_count_out;
    assign o_last          = r_last;

endmodule

@@ hw/rtl/pirl_ctrl.sv @@
// ----------------------------------------------------------------------------
// pirl_ctrl
// Controller: sequences one item at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
module pirl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  pirl_pkg::t_dp_stat  i_stat,
    output pirl_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_MATCH = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // Result register may be loaded when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and command
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = pirl_pkg::OP_NONE;
        o_cmd.emit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = pirl_pkg::OP_LOAD;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.kind)
                    pirl_pkg::K_REMOVE_VAL: begin
                        o_cmd.op = pirl_pkg::OP_COMPARE;
                        n_state  = S_MATCH;
                    end
                    pirl_pkg::K_INSERT: begin
                        if (out_free) begin
                            o_cmd.op   = pirl_pkg::OP_INSERT;
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    pirl_pkg::K_REMOVE_POS: begin
                        if (out_free) begin
                            o_cmd.op   = pirl_pkg::OP_REMOVE_POS;
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            o_cmd.emit = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.op = pirl_pkg::OP_READ_EMPTY;
                                n_state  = S_IDLE;
                            end else begin
                                o_cmd.op = pirl_pkg::OP_READ_ONE;
                                n_state  = i_stat.read_last ? S_IDLE : S_EMIT;
                            end
                        end
                    end
                endcase
            end
            S_MATCH: begin
                if (out_free) begin
                    o_cmd.op   = pirl_pkg::OP_REMOVE_FOUND;
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.op   = pirl_pkg::OP_READ_ONE;
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.read_last ? S_IDLE : S_EMIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Set on a new result, drop once the transfer completes
    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/pirl_checker.sv @@
// ----------------------------------------------------------------------------
// pirl_checker
// Port-level checks of the list unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pirl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [pirl_pkg::STATUS_W-1:0]  o_status,
    input logic [pirl_pkg::ELEM_W-1:0]    o_element,
    input logic [pirl_pkg::COUNT_W-1:0]   o_count,
    input logic                           o_last
);

    // A pending result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // One item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in work");

    // Error and empty results are single, with no element
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != pirl_pkg::ST_OK) |-> o_last && (o_element == '0))
        else $error("error result not final or carries data");

    // Read-all results follow back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_out_valid)
        else $error("read-all burst broken");

    // Count stays fixed across a read-all burst
    a_burst_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_count == $past(o_count))
        else $error("count changed within read-all burst");

endmodule

bind positional_insert_remove_list_unit pirl_checker u_pirl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_element   (o_element),
    .o_count     (o_count),
    .o_last      (o_last)
);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional insert/remove list. A shadow copy of
// the list predicts every result at input transfer time; the receiver checks
// results in order against it under random gaps, stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        pirl_pkg::t_kind                kind;
        logic [pirl_pkg::POS_W-1:0]     position;
        logic [pirl_pkg::VALUE_W-1:0]   value;
    } t_list_op;

    typedef struct {
        pirl_pkg::t_status              status;
        logic [pirl_pkg::ELEM_W-1:0]    element;
        logic [pirl_pkg::INDEX_W-1:0]   index;
        logic [pirl_pkg::COUNT_W-1:0]   count;
        logic                           last;
    } t_list_result;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [pirl_pkg::KIND_W-1:0]    in_kind = '0;
    logic [pirl_pkg::POS_W-1:0]     in_position = '0;
    logic [pirl_pkg::VALUE_W-1:0]   in_value = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [pirl_pkg::STATUS_W-1:0]  out_status;
    logic [pirl_pkg::ELEM_W-1:0]    out_element;
    logic [pirl_pkg::INDEX_W-1:0]   out_index;
    logic [pirl_pkg::COUNT_W-1:0]   out_count;
    logic                           out_last;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [pirl_pkg::VALUE_W-1:0]   cfg_data = '0;

    // Operations waiting to be offered, masks waiting to be written
    t_list_op                       op_backlog[$];
    logic [pirl_pkg::VALUE_W-1:0]   mask_backlog[$];
    // Results the list owes, oldest first
    t_list_result                   due_results[$];

    // Shadow of the list state
    logic [pirl_pkg::VALUE_W-1:0]   shadow_entries[pirl_pkg::CAPACITY_DEF];
    int                             shadow_count = 0;
    logic [pirl_pkg::VALUE_W-1:0]   shadow_mask = '1;

    t_list_op                       cur_op;
    int                             feed_gap = 0;
    int                             drain_wait = 0;
    bit                             steady_feed = 1'b0;
    bit                             steady_drain = 1'b0;
    int                             hold_requests = 0;
    int                             hold_seen = 0;
    int                             hold_left = 0;
    int                             mismatches = 0;
    logic [pirl_pkg::VALUE_W-1:0]   value_pool[8];

    positional_insert_remove_list_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_kind          (in_kind),
        .i_position      (in_position),
        .i_value         (in_value),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (out_status),
        .o_element       (out_element),
        .o_element_index (out_index),
        .o_count         (out_count),
        .o_last          (out_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Mostly back to back, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic owe_result(input pirl_pkg::t_status st,
                              input logic [pirl_pkg::ELEM_W-1:0] elem,
                              input int idx, input logic last);
        t_list_result r;
        r.status  = st;
        r.element = elem;
        r.index   = idx[pirl_pkg::INDEX_W-1:0];
        r.count   = shadow_count[pirl_pkg::COUNT_W-1:0];
        r.last    = last;
        due_results.push_back(r);
    endtask

    // Apply one operation to the shadow list and queue what it must emit
    task automatic apply_list_op(input t_list_op op);
        int p;
        int i;
        int hit;
        p = int'(op.position);
        case (op.kind)
            pirl_pkg::K_INSERT: begin
                if (shadow_count >= pirl_pkg::CAPACITY_DEF) begin
                    owe_result(pirl_pkg::ST_FULL, '0, 0, 1'b1);
                end else begin
                    if (p > shadow_count) p = shadow_count;
                    for (i = shadow_count; i > p; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[p] = op.value;
                    shadow_count++;
                    owe_result(pirl_pkg::ST_OK, '0, 0, 1'b1);
                end
            end
            pirl_pkg::K_REMOVE_POS: begin
                if (p >= shadow_count) begin
                    owe_result(pirl_pkg::ST_BAD_POS, '0, 0, 1'b1);
                end else begin
                    for (i = p; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                    owe_result(pirl_pkg::ST_OK, '0, 0, 1'b1);
                end
            end
            pirl_pkg::K_REMOVE_VAL: begin
                hit = -1;
                for (i = 0; i < shadow_count && hit < 0; i++)
                    if (((shadow_entries[i] ^ op.value) & shadow_mask) == '0) hit = i;
                if (hit < 0) begin
                    owe_result(pirl_pkg::ST_NOT_FOUND, '0, 0, 1'b1);
                end else begin
                    for (i = hit; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                    owe_result(pirl_pkg::ST_OK, '0, hit, 1'b1);
                end
            end
            default: begin
                if (shadow_count == 0)
                    owe_result(pirl_pkg::ST_EMPTY, '0, 0, 1'b1);
                for (i = 0; i < shadow_count; i++)
                    owe_result(pirl_pkg::ST_OK, shadow_entries[i], i,
                               i + 1 == shadow_count);
            end
        endcase
    endtask

    // Driver: record accepted transfers, then offer the next operation or mask
    always @(posedge clk) begin : feed
        t_list_op nxt;
        if (cfg_valid && cfg_ready) begin
            shadow_mask = cfg_data;
            cfg_valid <= 1'b0;
        end else if (!cfg_valid && mask_backlog.size() != 0) begin
            cfg_data  <= mask_backlog.pop_front();
            cfg_valid <= 1'b1;
        end

        if (in_valid && !in_stall)
            apply_list_op(cur_op);
        if (!in_valid || !in_stall) begin
            if (feed_gap > 0 || op_backlog.size() == 0) begin
                if (feed_gap > 0) feed_gap--;
                in_valid <= 1'b0;
            end else begin
                nxt = op_backlog.pop_front();
                cur_op = nxt;
                in_kind     <= nxt.kind;
                in_position <= nxt.position;
                in_value    <= nxt.value;
                in_valid    <= 1'b1;
                feed_gap = steady_feed ? 0 : gap_len();
            end
        end
    end

    // Long receiver hold-off, counted here on request
    always @(posedge clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check each result transfer against the oldest one owed
    always @(posedge clk) begin : drain
        t_list_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing owed, status", out_status, 0);
            end else begin
                want = due_results.pop_front();
                if (out_status !== want.status)
                    report_mismatch("status", out_status, want.status);
                if (out_element !== want.element)
                    report_mismatch("element", out_element, want.element);
                if (out_index !== want.index)
                    report_mismatch("element_index", out_index, want.index);
                if (out_count !== want.count)
                    report_mismatch("count", out_count, want.count);
                if (out_last !== want.last)
                    report_mismatch("last", out_last, want.last);
            end
        end

        if (drain_wait > 0)
            drain_wait--;
        else if (!steady_drain && $urandom_range(0, 3) == 0)
            drain_wait = gap_len();
        out_stall <= (drain_wait > 0) || (hold_left != 0);
    end

    task automatic queue_op(input pirl_pkg::t_kind kind, input int pos,
                            input logic [pirl_pkg::VALUE_W-1:0] val);
        t_list_op op;
        op.kind     = kind;
        op.position = pos[pirl_pkg::POS_W-1:0];
        op.value    = val;
        op_backlog.push_back(op);
    endtask

    // Wait until nothing is queued, in flight or owed
    task automatic wait_idle();
        do @(negedge clk);
        while (op_backlog.size() != 0 || in_valid || due_results.size() != 0 ||
               mask_backlog.size() != 0 || cfg_valid);
    endtask

    task automatic write_mask(input logic [pirl_pkg::VALUE_W-1:0] m);
        mask_backlog.push_back(m);
        wait_idle();
    endtask

    function automatic logic [pirl_pkg::VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return value_pool[$urandom_range(0, 7)];
        if (r < 85) return value_pool[$urandom_range(0, 7)] ^ ($urandom() << 16);
        return $urandom();
    endfunction

    // Random traffic in chunks, with idling switched on or off per chunk
    task automatic random_phase(input int n_ops);
        int n;
        int r;
        int pos;
        pirl_pkg::t_kind kind;
        for (n = 0; n < n_ops; n++) begin
            if (n % 20 == 0) begin
                wait_idle();
                steady_feed  = ($urandom_range(0, 3) == 0);
                steady_drain = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 40)      kind = pirl_pkg::K_INSERT;
            else if (r < 60) kind = pirl_pkg::K_REMOVE_POS;
            else if (r < 85) kind = pirl_pkg::K_REMOVE_VAL;
            else             kind = pirl_pkg::K_READ_ALL;
            pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 17);
            queue_op(kind, pos, pick_value());
        end
        wait_idle();
    endtask

    initial begin : stimulus
        int n;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h5555_5555;
        value_pool[3] = 32'hAAAA_AAAA;
        for (n = 4; n < 8; n++) value_pool[n] = $urandom();

        // Hold reset, then release
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty list cases, append beyond count, field extremes
        queue_op(pirl_pkg::K_READ_ALL, 0, '0);
        queue_op(pirl_pkg::K_REMOVE_POS, 0, '0);
        queue_op(pirl_pkg::K_REMOVE_VAL, 0, 32'hFFFF_FFFF);
        queue_op(pirl_pkg::K_INSERT, 255, 32'hFFFF_FFFF);
        queue_op(pirl_pkg::K_INSERT, 0, 32'h0000_0000);
        queue_op(pirl_pkg::K_INSERT, 1, 32'hA5A5_A5A5);
        queue_op(pirl_pkg::K_READ_ALL, 0, '0);
        queue_op(pirl_pkg::K_REMOVE_POS, 255, '0);
        queue_op(pirl_pkg::K_REMOVE_POS, 2, '0);
        queue_op(pirl_pkg::K_REMOVE_VAL, 0, 32'hA5A5_A5A5);
        queue_op(pirl_pkg::K_REMOVE_VAL, 0, 32'h1234_5678);
        wait_idle();

        // Fill to full behind a long receiver hold-off, overflow, drain
        write_mask(32'h0000_FFFF);
        hold_requests++;
        for (n = 0; n < 17; n++)
            queue_op(pirl_pkg::K_INSERT, $urandom_range(0, 20), pick_value());
        queue_op(pirl_pkg::K_READ_ALL, 0, '0);
        queue_op(pirl_pkg::K_REMOVE_POS, pirl_pkg::CAPACITY_DEF - 1, '0);
        queue_op(pirl_pkg::K_REMOVE_VAL, 0, value_pool[2] ^ 32'hFFFF_0000);
        queue_op(pirl_pkg::K_READ_ALL, 0, '0);
        wait_idle();

        random_phase(50);
        write_mask(32'h0000_0000);
        random_phase(45);
        write_mask(32'hFFFF_FFFF);
        random_phase(50);
        write_mask($urandom() | 32'h0000_00F0);
        random_phase(45);

        // Let any trailing result show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (due_results.size() != 0)
            report_mismatch("results never delivered", due_results.size(), 0);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Give up after a generous bound
    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
